[hdl/tpsl_pkg.sv]
// Shared types and constants for the timer period sync loop.
// Used by the top level and the shared multiplier.
`default_nettype none

package tpsl_pkg;

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEFF     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISCARD_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D           = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTERING_OFFSET = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MIN       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MAX       = 3'd7;

  // operation codes
  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_CHECK   = 1'b1;

  localparam logic [15:0] RELOAD_TOP = 16'hffff;

  // request into the shared multiplier
  typedef struct packed {
    logic                      load;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

`default_nettype wire

[hdl/tpsl_mul.sv]
// Shared signed 32x18 multiplier with a registered product.
// Depends on tpsl_pkg for the request type and widths.
`default_nettype none

module tpsl_mul (
  input  wire logic                                  clk,
  input  wire tpsl_pkg::mul_req_t                    req,
  output logic signed [tpsl_pkg::PROD_W-1:0]         prod
);

  always_ff @(posedge clk) begin
    if (req.load) begin
      prod <= tpsl_pkg::PROD_W'(req.a) * tpsl_pkg::PROD_W'(req.b);
    end
  end

endmodule

`default_nettype wire

[hdl/timer_period_sync_loop.sv]
// Timer period sync loop, top level. Uses tpsl_pkg and tpsl_mul.
// A capture item steps through the sequencer states S_SP_MUL to S_STEP, a
// check tick through S_CHK_MUL and S_CHK; either waits in its last state
// until the result register is free. A new item is taken only back in S_IDLE,
// so items never overlap; the sequencer steps the single shared multiplier.
// Reset (synchronous, active high): configuration registers to defaults, loop state to zero.
`default_nettype none

module timer_period_sync_loop #(
  parameter int HIRES_SCALE = 16384
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               operation,
  input  wire logic [15:0]                        capture_count,
  input  wire logic [15:0]                        tick_count,
  input  wire logic [15:0]                        timer_reload,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    reload_write,
  output logic [15:0]                             new_reload,
  output logic signed [14:0]                      half_reload,
  output logic signed [15:0]                      correction,
  output logic signed [31:0]                      inst_period,
  output logic                                    sync_valid,
  input  wire logic                               cfg_write,
  input  wire logic [tpsl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tpsl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SP_MUL  = 4'd1;
  localparam logic [3:0] S_SP      = 4'd2;
  localparam logic [3:0] S_INST    = 4'd3;
  localparam logic [3:0] S_DEV     = 4'd4;
  localparam logic [3:0] S_MAG     = 4'd5;
  localparam logic [3:0] S_OUTL    = 4'd6;
  localparam logic [3:0] S_AVG1    = 4'd7;
  localparam logic [3:0] S_AVG2    = 4'd8;
  localparam logic [3:0] S_AVG3    = 4'd9;
  localparam logic [3:0] S_PD1     = 4'd10;
  localparam logic [3:0] S_PD2     = 4'd11;
  localparam logic [3:0] S_PD3     = 4'd12;
  localparam logic [3:0] S_STEP    = 4'd13;
  localparam logic [3:0] S_CHK_MUL = 4'd14;
  localparam logic [3:0] S_CHK     = 4'd15;

  localparam logic [tpsl_pkg::MUL_B_W-1:0] SCALE_B = tpsl_pkg::MUL_B_W'(HIRES_SCALE);

  // configuration
  logic [15:0] filter_coeff;
  logic [30:0] peak_threshold;
  logic [15:0] discard_limit;
  logic [15:0] gain_p;
  logic [15:0] gain_d;
  logic [15:0] centering_offset;
  logic [15:0] period_min;
  logic [15:0] period_max;

  // loop state
  logic [31:0] prev_sample_point;
  logic [31:0] avg_period;
  logic [15:0] discard_counter;
  logic [15:0] prev_phase_error;
  logic [31:0] last_sample_point;
  logic        locked_flag;

  // working registers
  logic [3:0]  state;
  logic [3:0]  state_next;
  logic [15:0] cap;
  logic [15:0] tick;
  logic [15:0] reload;
  logic [31:0] sp;
  logic [31:0] inst;
  logic [31:0] inst_raw;
  logic [31:0] dev;
  logic        outlier;
  logic [31:0] acc;
  logic [15:0] phase;
  logic [15:0] corr;

  tpsl_pkg::mul_req_t                   mreq;
  logic signed [tpsl_pkg::PROD_W-1:0]   prod;

  logic [15:0] cap_diff;
  logic [16:0] phase_delta;
  logic [17:0] inv_coeff;
  logic [31:0] mag;
  logic [14:0] pd_sum;
  logic [15:0] chk_v;
  logic        chk_drop;
  logic        slot_free;
  logic [15:0] step_min;
  logic [15:0] step_max;
  logic        step_up;
  logic        step_down;
  logic [15:0] res_reload;
  logic        res_write;
  logic [15:0] half_sum;

  tpsl_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  assign cap_diff    = cap - reload;
  assign phase_delta = {phase[15], phase} - {prev_phase_error[15], prev_phase_error};
  assign inv_coeff   = 18'h10000 - {2'b00, filter_coeff};
  assign mag         = dev[31] ? (32'd0 - dev) : dev;
  assign pd_sum      = acc[14:0] + prod[30:16];
  assign chk_v       = prod[15:0] + last_sample_point[31:16] - tick;
  assign chk_drop    = (discard_counter == 16'd0) || chk_v[15];

  assign step_min  = tpsl_pkg::RELOAD_TOP - period_min;
  assign step_max  = tpsl_pkg::RELOAD_TOP - period_max;
  assign step_up   = corr[15] && (reload < step_min);
  assign step_down = !corr[15] && (corr != 16'd0) && (reload > step_max);

  always_comb begin
    res_write  = 1'b0;
    res_reload = reload;
    if (state == S_STEP) begin
      if (step_up) begin
        res_write  = 1'b1;
        res_reload = reload + 16'd1;
      end else if (step_down) begin
        res_write  = 1'b1;
        res_reload = reload - 16'd1;
      end
    end
  end

  // halve toward zero: add one to negative values before the shift
  assign half_sum = res_reload + {15'd0, res_reload[15]};

  // operand select for the shared multiplier
  always_comb begin
    mreq.load = 1'b0;
    mreq.a    = '0;
    mreq.b    = '0;
    unique case (state)
      S_SP_MUL: begin
        mreq.load = 1'b1;
        mreq.a    = {{16{cap_diff[15]}}, cap_diff};
        mreq.b    = SCALE_B;
      end
      S_AVG1: begin
        mreq.load = 1'b1;
        mreq.a    = avg_period;
        mreq.b    = {2'b00, filter_coeff};
      end
      S_AVG2: begin
        mreq.load = 1'b1;
        mreq.a    = inst;
        mreq.b    = inv_coeff;
      end
      S_PD1: begin
        mreq.load = 1'b1;
        mreq.a    = {{16{phase[15]}}, phase};
        mreq.b    = {{2{gain_p[15]}}, gain_p};
      end
      S_PD2: begin
        mreq.load = 1'b1;
        mreq.a    = {{15{phase_delta[16]}}, phase_delta};
        mreq.b    = {{2{gain_d[15]}}, gain_d};
      end
      S_CHK_MUL: begin
        mreq.load = 1'b1;
        mreq.a    = {16'd0, avg_period[31:16]};
        mreq.b    = {2'b00, discard_limit};
      end
      default: begin
        mreq.load = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (operation == tpsl_pkg::OP_CHECK) ? S_CHK_MUL : S_SP_MUL;
        end
      end
      S_SP_MUL:  state_next = S_SP;
      S_SP:      state_next = S_INST;
      S_INST:    state_next = S_DEV;
      S_DEV:     state_next = S_MAG;
      S_MAG:     state_next = S_OUTL;
      S_OUTL:    state_next = S_AVG1;
      S_AVG1:    state_next = S_AVG2;
      S_AVG2:    state_next = S_AVG3;
      S_AVG3:    state_next = S_PD1;
      S_PD1:     state_next = S_PD2;
      S_PD2:     state_next = S_PD3;
      S_PD3:     state_next = S_STEP;
      S_STEP:    state_next = slot_free ? S_IDLE : S_STEP;
      S_CHK_MUL: state_next = S_CHK;
      S_CHK:     state_next = slot_free ? S_IDLE : S_CHK;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_coeff     <= 16'd64000;
      peak_threshold   <= 31'd2000;
      discard_limit    <= 16'd16;
      gain_p           <= 16'd24000;
      gain_d           <= 16'd8192;
      centering_offset <= 16'd32767;
      period_min       <= 16'd0;
      period_max       <= 16'hffff;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tpsl_pkg::REG_FILTER_COEFF:     filter_coeff     <= cfg_data[15:0];
        tpsl_pkg::REG_PEAK_THRESHOLD:   peak_threshold   <= cfg_data;
        tpsl_pkg::REG_DISCARD_LIMIT:    discard_limit    <= cfg_data[15:0];
        tpsl_pkg::REG_GAIN_P:           gain_p           <= cfg_data[15:0];
        tpsl_pkg::REG_GAIN_D:           gain_d           <= cfg_data[15:0];
        tpsl_pkg::REG_CENTERING_OFFSET: centering_offset <= cfg_data[15:0];
        tpsl_pkg::REG_PERIOD_MIN:       period_min       <= cfg_data[15:0];
        tpsl_pkg::REG_PERIOD_MAX:       period_max       <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample_point <= 32'd0;
      avg_period        <= 32'd0;
      discard_counter   <= 16'd0;
      prev_phase_error  <= 16'd0;
      last_sample_point <= 32'd0;
      locked_flag       <= 1'b0;
    end else begin
      case (state)
        S_INST: begin
          prev_sample_point <= sp;
        end
        S_OUTL: begin
          if (outlier) begin
            if (discard_counter != 16'd0) begin
              discard_counter   <= discard_counter - 16'd1;
              last_sample_point <= last_sample_point + avg_period;
            end else begin
              last_sample_point <= sp;
            end
          end else begin
            last_sample_point <= sp;
            if (discard_counter < discard_limit) begin
              discard_counter <= discard_counter + 16'd1;
            end else begin
              locked_flag <= 1'b1;
            end
          end
        end
        S_AVG3: begin
          avg_period <= acc + prod[47:16];
        end
        S_PD3: begin
          prev_phase_error <= phase;
        end
        S_CHK: begin
          if (slot_free && chk_drop) begin
            discard_counter <= 16'd0;
            locked_flag     <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // item payload and working values
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cap    <= capture_count;
      tick   <= tick_count;
      reload <= timer_reload;
    end
    case (state)
      S_SP: begin
        sp <= prod[34:3] + {tick, 16'd0};
      end
      S_INST: begin
        inst     <= sp - prev_sample_point;
        inst_raw <= sp - prev_sample_point;
      end
      S_DEV: begin
        dev <= inst - avg_period;
      end
      S_MAG: begin
        outlier <= (mag >= {1'b0, peak_threshold});
      end
      S_OUTL: begin
        if (outlier && (discard_counter != 16'd0)) begin
          inst <= avg_period;
        end
      end
      S_AVG2: begin
        acc <= prod[47:16];
      end
      S_AVG3: begin
        phase <= last_sample_point[15:0] - centering_offset;
      end
      S_PD2: begin
        acc <= prod[47:16];
      end
      S_PD3: begin
        corr <= {pd_sum, 1'b0};
      end
      default: begin
      end
    endcase
  end

  // result register; holds until transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (((state == S_STEP) || (state == S_CHK)) && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (((state == S_STEP) || (state == S_CHK)) && slot_free) begin
      reload_write <= res_write;
      new_reload   <= res_reload;
      half_reload  <= half_sum[15:1];
      if (state == S_STEP) begin
        correction  <= corr;
        inst_period <= inst_raw;
        sync_valid  <= locked_flag;
      end else begin
        correction  <= 16'd0;
        inst_period <= 32'd0;
        sync_valid  <= chk_drop ? 1'b0 : locked_flag;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/tpsl_check.sv]
// Port checker for the timer period sync loop, bound to the top level.
// Sees the top level's ports only; no package dependency.
`default_nettype none

module tpsl_check (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               reload_write,
  input wire logic [15:0]        new_reload,
  input wire logic signed [14:0] half_reload,
  input wire logic signed [15:0] correction
);

  logic [15:0] half_sum;

  assign half_sum = new_reload + {15'd0, new_reload[15]};

  // busy after every transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an input transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(new_reload)))
    else $error("stalled result changed or dropped");

  a_write_needs_corr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reload_write) |-> (correction != 16'sd0))
    else $error("reload step without correction");

  a_half_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (half_reload == half_sum[15:1]))
    else $error("half_reload does not match new_reload");

endmodule

bind timer_period_sync_loop tpsl_check u_tpsl_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .reload_write (reload_write),
  .new_reload   (new_reload),
  .half_reload  (half_reload),
  .correction   (correction)
);

`default_nettype wire
